// ===== src/source_code_tokenizer_defines.svh =====
// Assertion macros for the source code tokenizer.
`ifndef SOURCE_CODE_TOKENIZER_DEFINES_SVH
`define SOURCE_CODE_TOKENIZER_DEFINES_SVH
`ifndef ASSERT_OFF
`define SCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SCT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCT_ASSERT(lbl, prop, msg)
`define SCT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== src/sct_pkg.sv =====
// Types, constants and scan functions for the source code tokenizer.
package sct_pkg;

  localparam int OFFSET_BITS = 20;
  localparam int LINE_BITS   = 16;
  localparam int COLUMN_BITS = 12;
  localparam int LENGTH_BITS = 12;
  localparam int KW_DEPTH    = 11;
  localparam int MAX_RES     = 3;

  typedef enum logic [4:0] {
    M_IDLE, M_NUM, M_ID, M_IDC1, M_IDCC, M_OP, M_OPSL, M_STR, M_STRBS,
    M_CH1, M_CHBS, M_CHCL, M_LCOM, M_BCOM, M_BCSTAR, M_ERRW, M_DONE
  } mode_t;

  typedef enum logic [3:0] {
    K_INT, K_FLT, K_ID, K_KW, K_BOOL, K_NULL, K_STR, K_CHR, K_OP, K_SEP,
    K_END, K_CHERR
  } kind_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic [3:0]             token_kind;
    logic [OFFSET_BITS-1:0] start_offset;
    logic [LINE_BITS-1:0]   line_number;
    logic [COLUMN_BITS-1:0] start_column;
    logic [LENGTH_BITS-1:0] token_length;
    logic                   last_of_run;
  } out_word_t;

  typedef struct packed {
    mode_t                           mode;
    logic [KW_DEPTH-1:0][7:0]        kb;
    logic [LENGTH_BITS-1:0]          len;
    logic [OFFSET_BITS-1:0]          tso;
    logic [COLUMN_BITS-1:0]          tsc;
    logic [OFFSET_BITS-1:0]          off;
    logic [LINE_BITS-1:0]            line;
    logic [COLUMN_BITS-1:0]          col;
    logic                            dot;
    logic                            ca;
    logic [1:0]                      n;
    logic [MAX_RES-1:0][$bits(out_word_t)-1:0] res;
  } ctx_t;

  function automatic logic is_ws(logic [7:0] b);
    return (b == 8'h20) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_dig(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_wordc(logic [7:0] b);
    return is_alpha(b) || is_dig(b) || b == "_";
  endfunction

  function automatic logic is_sep(logic [7:0] b);
    return b == ";" || b == "," || b == "(" || b == ")" || b == "{" || b == "}";
  endfunction

  function automatic logic is_op(logic [7:0] b);
    return b == "+" || b == "-" || b == "*" || b == "/" || b == "%" || b == "=" ||
           b == "<" || b == ">" || b == "!" || b == "&" || b == "|" || b == "^" ||
           b == "~";
  endfunction

  function automatic ctx_t emit(ctx_t c, kind_t k, logic [OFFSET_BITS-1:0] o,
                                logic [COLUMN_BITS-1:0] cl, logic [LENGTH_BITS-1:0] l);
    out_word_t w;
    w.token_kind   = k;
    w.start_offset = o;
    w.line_number  = c.line;
    w.start_column = cl;
    w.token_length = l;
    w.last_of_run  = 1'b0;
    if (c.n < 2'(MAX_RES)) begin
      c.res[c.n] = w;
      c.n = c.n + 2'd1;
    end
    return c;
  endfunction

  function automatic ctx_t emit_tok(ctx_t c, kind_t k);
    return emit(c, k, c.tso, c.tsc, c.len);
  endfunction

  function automatic ctx_t emit_end(ctx_t c);
    return emit(c, K_END, c.off, c.col, '0);
  endfunction

  function automatic ctx_t add_byte(ctx_t c, logic [7:0] b);
    if (c.len < LENGTH_BITS'(KW_DEPTH)) c.kb[c.len[3:0]] = b;
    if (c.len != '1) c.len = c.len + 1'b1;
    return c;
  endfunction

  function automatic ctx_t start_token(ctx_t c, logic [7:0] b);
    c.tso = c.off;
    c.tsc = c.col;
    c.len = '0;
    return add_byte(c, b);
  endfunction

  function automatic logic kw_hit(ctx_t c, logic [8*KW_DEPTH-1:0] pat, int l);
    logic hit;
    hit = (c.len == LENGTH_BITS'(l));
    for (int i = 0; i < KW_DEPTH; i++) begin
      if (i < l && c.kb[i] != pat[8*(l-1-i) +: 8]) hit = 1'b0;
    end
    return hit;
  endfunction

  function automatic kind_t ident_kind(ctx_t c);
    kind_t k;
    k = K_ID;
    if (kw_hit(c, "true", 4) || kw_hit(c, "false", 5)) k = K_BOOL;
    else if (kw_hit(c, "nullptr", 7)) k = K_NULL;
    else if (kw_hit(c, "int", 3) || kw_hit(c, "return", 6) || kw_hit(c, "if", 2) ||
             kw_hit(c, "else", 4) || kw_hit(c, "for", 3) || kw_hit(c, "while", 5) ||
             kw_hit(c, "float", 5) || kw_hit(c, "char", 4) ||
             kw_hit(c, "std::string", 11)) k = K_KW;
    return k;
  endfunction

  function automatic ctx_t dispatch(ctx_t c, logic [7:0] b);
    logic ca;
    ca = c.ca;
    c.mode = M_IDLE;
    c.ca = 1'b1;
    if (is_ws(b)) begin
    end else if (is_dig(b)) begin
      c = start_token(c, b);
      c.dot = 1'b0;
      c.mode = M_NUM;
    end else if (is_alpha(b) || b == "_") begin
      c = start_token(c, b);
      c.mode = M_ID;
    end else if (b == 8'h22) begin
      c = start_token(c, b);
      c.mode = M_STR;
    end else if (b == 8'h27) begin
      c = start_token(c, b);
      c.mode = M_CH1;
    end else if (is_op(b)) begin
      c = start_token(c, b);
      c.mode = (b == "/" && ca) ? M_OPSL : M_OP;
    end else if (is_sep(b)) begin
      c = start_token(c, b);
      c = emit_tok(c, K_SEP);
    end
    return c;
  endfunction

  function automatic ctx_t op_step(ctx_t c, logic [7:0] b);
    logic [7:0] f;
    f = c.kb[0];
    if (c.len == LENGTH_BITS'(1) && b == "=" &&
        (f == "=" || f == "!" || f == "<" || f == ">")) begin
      c = add_byte(c, b);
      c = emit_tok(c, K_OP);
      c.mode = M_IDLE;
    end else if (is_op(b)) begin
      c = add_byte(c, b);
      c.mode = M_OP;
    end else begin
      c = emit_tok(c, K_OP);
      c = dispatch(c, b);
    end
    return c;
  endfunction

  function automatic ctx_t feed(ctx_t c, logic [7:0] b);
    case (c.mode)
      M_NUM: begin
        if (is_dig(b)) c = add_byte(c, b);
        else if (b == "." && !c.dot) begin
          c = add_byte(c, b);
          c.dot = 1'b1;
        end else begin
          c = emit_tok(c, c.dot ? K_FLT : K_INT);
          c = dispatch(c, b);
        end
      end
      M_ID: begin
        if (is_wordc(b)) c = add_byte(c, b);
        else if (b == ":") c.mode = M_IDC1;
        else begin
          c = emit_tok(c, ident_kind(c));
          c = dispatch(c, b);
        end
      end
      M_IDC1: begin
        if (b == ":") begin
          c = add_byte(c, ":");
          c = add_byte(c, ":");
          c.mode = M_IDCC;
        end else begin
          c = emit_tok(c, ident_kind(c));
          c = dispatch(c, ":");
          c = dispatch(c, b);
        end
      end
      M_IDCC: begin
        if (is_wordc(b)) begin
          c = add_byte(c, b);
          c.mode = M_ID;
        end else begin
          c = emit_tok(c, ident_kind(c));
          c = dispatch(c, b);
        end
      end
      M_OPSL: begin
        if (b == "/") c.mode = M_LCOM;
        else if (b == "*") c.mode = M_BCOM;
        else c = op_step(c, b);
      end
      M_OP: c = op_step(c, b);
      M_STR: begin
        c = add_byte(c, b);
        if (b == 8'h22) begin
          c = emit_tok(c, K_STR);
          c.mode = M_IDLE;
        end else if (b == 8'h5c) c.mode = M_STRBS;
      end
      M_STRBS: begin
        c = add_byte(c, b);
        c.mode = (b == 8'h5c) ? M_STRBS : M_STR;
      end
      M_CH1: begin
        c = add_byte(c, b);
        c.mode = (b == 8'h5c) ? M_CHBS : M_CHCL;
      end
      M_CHBS: begin
        if (b == 8'h27) c.mode = M_CHCL;
        else begin
          c = emit_tok(c, K_CHERR);
          c.mode = M_ERRW;
        end
      end
      M_CHCL: begin
        if (b == 8'h27) begin
          c = add_byte(c, b);
          c = emit_tok(c, K_CHR);
          c.mode = M_IDLE;
        end else begin
          c = emit_tok(c, K_CHERR);
          c.mode = M_ERRW;
        end
      end
      M_LCOM: begin
        if (b == 8'h0a) begin
          c.mode = M_IDLE;
          c.ca = 1'b0;
        end
      end
      M_BCOM: begin
        if (b == "*") c.mode = M_BCSTAR;
      end
      M_BCSTAR: begin
        if (b == "/") begin
          c.mode = M_IDLE;
          c.ca = 1'b0;
        end else if (b != "*") c.mode = M_BCOM;
      end
      M_IDLE: c = dispatch(c, b);
      default: ;
    endcase
    return c;
  endfunction

  function automatic ctx_t feed_end(ctx_t c);
    case (c.mode)
      M_NUM: c = emit_tok(c, c.dot ? K_FLT : K_INT);
      M_ID, M_IDC1, M_IDCC: c = emit_tok(c, ident_kind(c));
      M_OP, M_OPSL: c = emit_tok(c, K_OP);
      M_STR, M_STRBS: begin
        c = add_byte(c, 8'h00);
        c = emit_tok(c, K_STR);
      end
      M_CH1, M_CHBS, M_CHCL: c = emit_tok(c, K_CHERR);
      default: ;
    endcase
    return emit_end(c);
  endfunction

  function automatic ctx_t advance(ctx_t c, logic [7:0] b);
    if (c.off != '1) c.off = c.off + 1'b1;
    if (b == 8'h0a) begin
      if (c.line != '1) c.line = c.line + 1'b1;
      c.col = COLUMN_BITS'(1);
    end else if (c.col != '1) begin
      c.col = c.col + 1'b1;
    end
    return c;
  endfunction

  function automatic ctx_t clear_state(ctx_t c);
    c.mode = M_IDLE;
    c.len  = '0;
    c.tso  = '0;
    c.tsc  = COLUMN_BITS'(1);
    c.off  = '0;
    c.line = LINE_BITS'(1);
    c.col  = COLUMN_BITS'(1);
    c.dot  = 1'b0;
    c.ca   = 1'b1;
    return c;
  endfunction

  function automatic ctx_t step(ctx_t c, logic [7:0] b, logic fin);
    out_word_t w;
    c.n = '0;
    if (c.mode == M_DONE) begin
      if (fin) c = clear_state(c);
    end else if (c.mode == M_ERRW) begin
      c = advance(c, b);
      if (fin) begin
        c = emit_end(c);
        c = clear_state(c);
      end
    end else if (b == 8'h00) begin
      c = feed_end(c);
      if (fin) c = clear_state(c);
      else c.mode = M_DONE;
    end else begin
      c = feed(c, b);
      c = advance(c, b);
      if (fin) begin
        c = feed_end(c);
        c = clear_state(c);
      end
    end
    if (c.n != '0) begin
      w = c.res[c.n - 2'd1];
      w.last_of_run = 1'b1;
      c.res[c.n - 2'd1] = w;
    end
    return c;
  endfunction

endpackage

// ===== src/source_code_tokenizer.sv =====
// Top level of the source code tokenizer: scan state and result queue.
// One source byte is taken per cycle and scanned in the same cycle; the
// zero to three token words it produces go into a four-entry result queue
// that drains one word per cycle while out_stall is low. The input stalls
// while the queue holds more than one word, so with the output unstalled the
// sustained rate is one byte per cycle while bytes average at most one token
// word each; extra words hold the input until the queue drains to one.
`include "source_code_tokenizer_defines.svh"
module source_code_tokenizer
  import sct_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  ctx_t      st_r, st_nxt, cur;
  out_word_t q_r [4];
  logic [1:0] wr_r, rd_r;
  logic [2:0] cnt_r, cnt_nxt;
  logic acc, pop;

  assign in_stall  = (cnt_r > 3'd1);
  assign acc       = in_valid && !in_stall;
  assign out_valid = (cnt_r != 3'd0);
  assign out_word  = q_r[rd_r];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    cur    = step(st_r, in_word.char_byte, in_word.final_byte);
    st_nxt = acc ? cur : st_r;
    cnt_nxt = cnt_r + (acc ? {1'b0, cur.n} : 3'd0) - (pop ? 3'd1 : 3'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= clear_state(st_r);
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      if (pop) rd_r <= rd_r + 2'd1;
      if (acc) wr_r <= wr_r + cur.n;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      for (int i = 0; i < MAX_RES; i++) begin
        if (2'(i) < cur.n) q_r[wr_r + 2'(i)] <= cur.res[i];
      end
    end
  end

  `SCT_ASSERT(a_cnt_bound, cnt_r <= 3'd4, "result queue overflow")
  `SCT_ASSERT(a_drain, pop && !acc |=> cnt_r == $past(cnt_r) - 3'd1, "queue drain count")
  `SCT_ASSERT(a_final_idle, acc && in_word.final_byte |=> st_r.mode == M_IDLE,
              "final byte must return scan to start")
  `SCT_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> cnt_r == 3'd0, "queue not empty after reset")

endmodule
